/* sv/hk512_pkg.sv */
// Package for the Haraka-512/256 hash pipeline.
// Holds the AES S-box, round helpers, round constants and the lane mix.
// Used by the hash top level and the AES stage; the checker needs no package.
package hk512_pkg;

  localparam int unsigned NumRounds = 5;
  localparam int unsigned NumAes    = 10;  // two AES rounds per Haraka round
  localparam int unsigned NumRc     = 40;

  typedef logic [127:0] lane_t;
  typedef lane_t [3:0] state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Round constants as 128-bit words, most significant 32-bit word first,
  // so byte i of the key sits in bits 8i+7:8i.
  localparam lane_t RC [NumRc] = '{
    128'h0684704c_e620c00a_b2c5fef0_75817b9d, 128'h8b66b4e1_88f3a06b_640f6ba4_2f08f717,
    128'h3402de2d_53f28498_cf029d60_9f029114, 128'h0ed6eae6_2e7b4f08_bbf3bcaf_fd5b4f79,
    128'hcbcfb0cb_4872448b_79eecd1c_be397044, 128'h7eeacdee_6e9032b7_8d5335ed_2b8a057b,
    128'h67c28f43_5e2e7cd0_e2412761_da4fef1b, 128'h2924d9b0_afcacc07_675ffde2_1fc70b3b,
    128'hab4d63f1_e6867fe9_ecdb8fca_b9d465ee, 128'h1c30bf84_d4b7cd64_5b2a404f_ad037e33,
    128'hb2cc0bb9_941723bf_69028b2e_8df69800, 128'hfa0478a6_de6f5572_4aaa9ec8_5c9d2d8a,
    128'hdfb49f2b_6b772a12_0efa4f2e_29129fd4, 128'h1ea10344_f449a236_32d611ae_bb6a12ee,
    128'haf044988_4b050084_5f9600c9_9ca8eca6, 128'h21025ed8_9d199c4f_78a2c7e3_27e593ec,
    128'hbf3aaaf8_a759c9b7_b9282ecd_82d40173, 128'h6260700d_6186b017_37f2efd9_10307d6b,
    128'h5aca45c2_21300443_81c29153_f6fc9ac6, 128'h9223973c_226b68bb_2caf92e8_36d1943a,
    128'hd3bf9238_225886eb_6cbab958_e51071b4, 128'hdb863ce5_aef0c677_933dfddd_24e1128d,
    128'hbb606268_ffeba09c_83e48de3_cb2212b1, 128'h734bd3dc_e2e4d19c_2db91a4e_c72bf77d,
    128'h43bb47c3_61301b43_4b1415c4_2cb3924e, 128'hdba775a8_e707eff6_03b231dd_16eb6899,
    128'h6df3614b_3c755977_8e5e2302_7eca472c, 128'hcda75a17_d6de7d77_6d1be5b9_b88617f9,
    128'hec6b43f0_6ba8e9aa_9d6c069d_a946ee5d, 128'hcb1e6950_f957332b_a2531159_3bf327c1,
    128'h2cee0c75_00da619c_e4ed0353_600ed0d9, 128'hf0b1a5a1_96e90cab_80bbbabc_63a4a350,
    128'hae3db102_5e962988_ab0dde30_938dca39, 128'h17bb8f38_d554a40b_8814f3a8_2e75b442,
    128'h34bb8a5b_5f427fd7_aeb6b779_360a16f6, 128'h26f65241_cbe55438_43ce5918_ffbaafde,
    128'h4ce99a54_b9f3026a_a2ca9cf7_839ec978, 128'hae51a51a_1bdff7be_40c06e28_22901235,
    128'ha0c1613c_ba7ed22b_c173bc0f_48a659cf, 128'h756acc03_02288288_4ad6bdfd_e9c59da1
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // One AES encryption round on a lane; byte i in bits 8i+7:8i.
  function automatic lane_t aes_round(input lane_t st, input lane_t key);
    logic [7:0] t [16];
    lane_t      o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = SBOX[st[8*(r + 4*((c + r) % 4)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c];
      a1 = t[4*c+1];
      a2 = t[4*c+2];
      a3 = t[4*c+3];
      o[8*(4*c)   +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      o[8*(4*c+1) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      o[8*(4*c+2) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      o[8*(4*c+3) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    aes_round = o ^ key;
  endfunction

  // Word interleave of two lanes: low half a0,b0,a1,b1, high half a2,b2,a3,b3.
  function automatic lane_t unpack_lo(input lane_t a, input lane_t b);
    unpack_lo = {b[63:32], a[63:32], b[31:0], a[31:0]};
  endfunction

  function automatic lane_t unpack_hi(input lane_t a, input lane_t b);
    unpack_hi = {b[127:96], a[127:96], b[95:64], a[95:64]};
  endfunction

  function automatic state_t lane_mix(input state_t s);
    lane_t  t, u, v, x;
    state_t o;
    t = unpack_lo(s[0], s[1]);
    u = unpack_hi(s[0], s[1]);
    v = unpack_lo(s[2], s[3]);
    x = unpack_hi(s[2], s[3]);
    o[0] = unpack_hi(u, x);
    o[3] = unpack_lo(u, x);
    o[2] = unpack_hi(v, t);
    o[1] = unpack_lo(v, t);
    lane_mix = o;
  endfunction

endpackage

/* sv/haraka_512_to_256_hash_top.sv */
// Top level of the Haraka-512/256 hash pipeline.
// Uses hk512_pkg and hk512_aes_stage.
//
// The block hashes one 64-byte request per clock cycle while the output is
// not stalled. It is a ten-stage pipeline, one register stage per AES round
// (two per Haraka round, the second also doing the lane mix), followed by
// one output register that holds the feed-forward xor and the truncation.
// The whole pipeline advances together whenever the output register is
// empty or being taken, so a stall on the output freezes every stage and
// nothing is lost or repeated; a new request is accepted in every cycle
// that the pipeline moves. The block keeps no state between requests.
module haraka_512_to_256_hash_top import hk512_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [63:0] msg_word_0_i,
  input  logic [63:0] msg_word_1_i,
  input  logic [63:0] msg_word_2_i,
  input  logic [63:0] msg_word_3_i,
  input  logic [63:0] msg_word_4_i,
  input  logic [63:0] msg_word_5_i,
  input  logic [63:0] msg_word_6_i,
  input  logic [63:0] msg_word_7_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [63:0] hash_word_0_o,
  output logic [63:0] hash_word_1_o,
  output logic [63:0] hash_word_2_o,
  output logic [63:0] hash_word_3_o
);

  state_t stg_state [NumAes+1];
  state_t stg_msg   [NumAes+1];
  logic   stg_valid [NumAes+1];
  logic   out_valid_q;
  logic   advance;
  logic [63:0] h0_q, h1_q, h2_q, h3_q;
  state_t fin;

  // The whole pipe moves when the output slot is free or being drained.
  assign advance = !out_valid_q || !stall_i;
  assign stall_o = !advance;

  assign stg_valid[0] = valid_i;
  assign stg_msg[0]   = '{ {msg_word_7_i, msg_word_6_i}, {msg_word_5_i, msg_word_4_i},
                           {msg_word_3_i, msg_word_2_i}, {msg_word_1_i, msg_word_0_i} };
  assign stg_state[0] = stg_msg[0];

  for (genvar g = 0; g < NumAes; g++) begin : g_round
    state_t key;
    assign key = '{RC[4*g+3], RC[4*g+2], RC[4*g+1], RC[4*g]};
    hk512_aes_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .valid_i (stg_valid[g]),
      .state_i (stg_state[g]),
      .msg_i   (stg_msg[g]),
      .key_i   (key),
      .mix_i   ((g % 2) == 1),
      .valid_o (stg_valid[g+1]),
      .state_o (stg_state[g+1]),
      .msg_o   (stg_msg[g+1])
    );
  end

  // Feed-forward with the message, then keep the digest halves.
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      fin[l] = stg_state[NumAes][l] ^ stg_msg[NumAes][l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= stg_valid[NumAes];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      h0_q <= fin[0][127:64];
      h1_q <= fin[1][127:64];
      h2_q <= fin[2][63:0];
      h3_q <= fin[3][63:0];
    end
  end

  assign valid_o       = out_valid_q;
  assign hash_word_0_o = h0_q;
  assign hash_word_1_o = h1_q;
  assign hash_word_2_o = h2_q;
  assign hash_word_3_o = h3_q;

endmodule

/* sv/hk512_aes_stage.sv */
// One pipeline stage: one AES round on all four lanes, optional lane mix.
// Uses hk512_pkg. The round index selects keys at elaboration via a port tie.
module hk512_aes_stage import hk512_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  state_t      state_i,
  input  state_t      msg_i,
  input  state_t      key_i,
  input  logic        mix_i,
  output logic        valid_o,
  output state_t      state_o,
  output state_t      msg_o
);

  state_t st_d, st_q, msg_q;
  logic   valid_q;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      st_d[l] = aes_round(state_i[l], key_i[l]);
    end
    if (mix_i) begin
      st_d = lane_mix(st_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q  <= st_d;
      msg_q <= msg_i;
    end
  end

  assign valid_o = valid_q;
  assign state_o = st_q;
  assign msg_o   = msg_q;

endmodule

/* sv/hk512_checker.sv */
// Port-level checker for the Haraka-512/256 hash top level.
// Bound to haraka_512_to_256_hash_top; needs no package.
module hk512_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [63:0] hash_word_0_o
);

  // A held result keeps its data.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(hash_word_0_o))
    else $error("result changed while stalled");

  // The block only stalls when its own result is stalled.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("stall without output backpressure");

  // An accepted request reaches the output once it has moved through every AES stage and the output register.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o ##1 !stall_o [*10] |=> valid_o)
    else $error("request did not reach the output in time");

  // The handshake outputs are always known out of reset.
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(valid_o) && !$isunknown(stall_o))
    else $error("unknown handshake output");

endmodule

bind haraka_512_to_256_hash_top hk512_checker u_hk512_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (valid_i),
  .stall_o       (stall_o),
  .valid_o       (valid_o),
  .stall_i       (stall_i),
  .hash_word_0_o (hash_word_0_o)
);
